FILE: rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed pool allocator package
// Shared widths, operation and status codes, and the free-list command type.
// ----------------------------------------------------------------------------
`default_nettype none

package fpa_pkg;

    localparam int SLOTS  = 64;
    localparam int SLOT_W = 6;
    localparam int CNT_W  = 7;

    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_EXHAUSTED  = 2'd1,
        STATUS_NOT_IN_USE = 2'd2
    } status_t;

    // Command from the allocator datapath to the free list.
    typedef struct packed {
        logic              push;
        logic              pop;
        logic [SLOT_W-1:0] slot;
    } stk_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/fpa_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/fpa_stack.sv
// ----------------------------------------------------------------------------
// Free-slot stack
// LIFO of free slot numbers. The top entry lives in a register, the entries
// below it in a RAM whose next-to-top word is always prefetched.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_stack (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         reinit,
    input  wire logic [fpa_pkg::CNT_W-1:0]    reinit_size,
    input  wire fpa_pkg::stk_cmd_t            cmd,
    output logic      [fpa_pkg::CNT_W-1:0]    count,
    output logic      [fpa_pkg::SLOT_W-1:0]   top
);

    import fpa_pkg::*;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SLOT_W-1:0] top_reg, top_next;
    logic [CNT_W-1:0]  low_reg, low_next;
    logic              byp_vld_reg, byp_vld_next;
    logic [SLOT_W-1:0] byp_reg, byp_next;
    logic              ident_reg, ident_next;

    logic [SLOT_W-1:0] ram_q;
    logic [SLOT_W-1:0] below;
    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  cnt_m2;
    logic [CNT_W-1:0]  rd_pos;
    logic              wr_en;

    // The low mark is the smallest depth seen since the pool was set up.
    // Every stack position at or above one below it has been written back
    // by a push; positions further down still hold their initial value,
    // which equals the position itself.
    assign cnt_m1 = cnt_reg - CNT_W'(1);
    assign cnt_m2 = cnt_reg - CNT_W'(2);

    always_comb
    begin
        if (byp_vld_reg)
        begin
            below = byp_reg;
        end
        else if (ident_reg)
        begin
            below = cnt_m2[SLOT_W-1:0];
        end
        else
        begin
            below = ram_q;
        end
    end

    always_comb
    begin
        cnt_next     = cnt_reg;
        top_next     = top_reg;
        byp_vld_next = 1'b0;
        byp_next     = top_reg;
        wr_en        = 1'b0;
        if (reinit)
        begin
            cnt_next = reinit_size;
            top_next = SLOT_W'(reinit_size - CNT_W'(1));
        end
        else if (cmd.pop)
        begin
            cnt_next = cnt_m1;
            top_next = below;
        end
        else if (cmd.push)
        begin
            // Spill the old top into the RAM and keep a copy, since the RAM
            // returns the old word when read and write hit the same address.
            cnt_next     = cnt_reg + CNT_W'(1);
            top_next     = cmd.slot;
            byp_vld_next = 1'b1;
            wr_en        = (cnt_reg != '0);
        end
    end

    always_comb
    begin
        if (reinit)
        begin
            low_next   = reinit_size;
            ident_next = 1'b1;
        end
        else
        begin
            low_next   = (cnt_next < low_reg) ? cnt_next : low_reg;
            ident_next = (low_next == cnt_next);
        end
    end

    assign rd_pos = cnt_next - CNT_W'(2);

    fpa_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (cnt_m1[SLOT_W-1:0]),
        .wdata (top_reg),
        .raddr (rd_pos[SLOT_W-1:0]),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= CNT_W'(SLOTS);
            top_reg     <= SLOT_W'(SLOTS - 1);
            low_reg     <= CNT_W'(SLOTS);
            byp_vld_reg <= 1'b0;
            ident_reg   <= 1'b1;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            top_reg     <= top_next;
            low_reg     <= low_next;
            byp_vld_reg <= byp_vld_next;
            ident_reg   <= ident_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byp_reg <= byp_next;
    end

    assign count = cnt_reg;
    assign top   = top_reg;

endmodule

`default_nettype wire

FILE: rtl/fixed_pool_allocator.sv
// ----------------------------------------------------------------------------
// Fixed pool allocator
// Hands out fixed-size buffer slots by index from a LIFO free list.
// ----------------------------------------------------------------------------
// An operation (func: allocate or free, slot_index) is taken when start is
// high and busy is low. It is registered, processed in the following cycle,
// and its result is shown in the cycle after that: done is high for exactly
// one cycle with status, granted_slot, free_count and high_water.
// One operation is taken every cycle while busy is low; the free-list stack
// holds its top entry in a register and prefetches the entry below it from
// its RAM, so back-to-back pops and pushes need no stall.
// The pool size register is written over the cfg channel (cfg_valid,
// cfg_ready, cfg_data). A write returns every slot to the free list in
// ascending order and clears the in-use map and the high-water mark. busy
// is high while a write is offered, and cfg_ready is low while an operation
// is still registered, so the two never overlap.
// Reset puts the pool in the same state as a write of 64 slots; no sweep
// over the RAM is needed. The receiver cannot stall: each result is shown
// for one cycle only.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_pool_allocator (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        func,
    input  wire logic [fpa_pkg::SLOT_W-1:0]  slot_index,
    output logic                             done,
    output logic      [1:0]                  status,
    output logic      [fpa_pkg::SLOT_W-1:0]  granted_slot,
    output logic      [fpa_pkg::CNT_W-1:0]   free_count,
    output logic      [fpa_pkg::CNT_W-1:0]   high_water,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [fpa_pkg::CNT_W-1:0]   cfg_data
);

    import fpa_pkg::*;

    logic              op_vld_reg;
    logic              func_reg;
    logic [SLOT_W-1:0] idx_reg;

    logic [CNT_W-1:0]  pool_size_reg, pool_size_next;
    logic [SLOTS-1:0]  slot_busy_reg, slot_busy_next;
    logic [CNT_W-1:0]  peak_reg, peak_next;

    logic              done_reg;
    status_t           status_reg, status_next;
    logic [SLOT_W-1:0] granted_reg, granted_next;
    logic [CNT_W-1:0]  free_cnt_reg, free_cnt_next;

    logic              cfg_fire;
    logic [CNT_W-1:0]  size_clamped;
    logic              is_alloc, is_free;
    logic              alloc_ok, free_ok;
    logic [CNT_W-1:0]  in_use;
    stk_cmd_t          stk_cmd;
    logic [CNT_W-1:0]  stk_count;
    logic [SLOT_W-1:0] stk_top;

    assign cfg_ready = ~op_vld_reg;
    assign cfg_fire  = cfg_valid & cfg_ready;
    assign busy      = cfg_valid;

    always_comb
    begin
        if (cfg_data == '0)
        begin
            size_clamped = CNT_W'(1);
        end
        else if (cfg_data > CNT_W'(SLOTS))
        begin
            size_clamped = CNT_W'(SLOTS);
        end
        else
        begin
            size_clamped = cfg_data;
        end
    end

    assign is_alloc = op_vld_reg & (func_reg == FUNC_ALLOC);
    assign is_free  = op_vld_reg & (func_reg == FUNC_FREE);
    assign alloc_ok = is_alloc & (stk_count != '0);
    // A slot outside the pool is never marked in use, but the range check
    // keeps a stale map bit from counting.
    assign free_ok  = is_free & ({1'b0, idx_reg} < pool_size_reg) &
                      slot_busy_reg[idx_reg] & (stk_count < CNT_W'(SLOTS));

    assign stk_cmd.pop  = alloc_ok;
    assign stk_cmd.push = free_ok;
    assign stk_cmd.slot = idx_reg;

    always_comb
    begin
        status_next    = STATUS_OK;
        granted_next   = '0;
        free_cnt_next  = stk_count;
        slot_busy_next = slot_busy_reg;
        peak_next      = peak_reg;
        pool_size_next = pool_size_reg;
        in_use         = pool_size_reg - stk_count;
        if (cfg_fire)
        begin
            pool_size_next = size_clamped;
            slot_busy_next = '0;
            peak_next      = '0;
        end
        else if (alloc_ok)
        begin
            granted_next            = stk_top;
            free_cnt_next           = stk_count - CNT_W'(1);
            in_use                  = pool_size_reg - free_cnt_next;
            slot_busy_next[stk_top] = 1'b1;
            if (in_use > peak_reg)
            begin
                peak_next = in_use;
            end
        end
        else if (free_ok)
        begin
            free_cnt_next           = stk_count + CNT_W'(1);
            slot_busy_next[idx_reg] = 1'b0;
        end
        else if (is_alloc)
        begin
            status_next = STATUS_EXHAUSTED;
        end
        else if (is_free)
        begin
            status_next = STATUS_NOT_IN_USE;
        end
    end

    fpa_stack u_stack (
        .clk         (clk),
        .rst_n       (rst_n),
        .reinit      (cfg_fire),
        .reinit_size (size_clamped),
        .cmd         (stk_cmd),
        .count       (stk_count),
        .top         (stk_top)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_vld_reg    <= 1'b0;
            done_reg      <= 1'b0;
            pool_size_reg <= CNT_W'(SLOTS);
            slot_busy_reg <= '0;
            peak_reg      <= '0;
        end
        else
        begin
            op_vld_reg    <= start & ~busy;
            done_reg      <= op_vld_reg;
            pool_size_reg <= pool_size_next;
            slot_busy_reg <= slot_busy_next;
            peak_reg      <= peak_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func;
        idx_reg      <= slot_index;
        status_reg   <= status_next;
        granted_reg  <= granted_next;
        free_cnt_reg <= free_cnt_next;
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign granted_slot = granted_reg;
    assign free_count   = free_cnt_reg;
    assign high_water   = peak_reg;

endmodule

`default_nettype wire
